>>> src/rcdt_pkg.sv
// ----------------------------------------------------------------------------
// RC discharge timer package
// Shared widths, register indexes, reset values and bundle types.
// ----------------------------------------------------------------------------
`default_nettype none

package rcdt_pkg;

   localparam int unsigned PIN_W        = 8;
   localparam int unsigned READING_W    = 16;
   localparam int unsigned NUM_READINGS = 8;
   localparam int unsigned CSR_IDX_W    = 2;
   localparam int unsigned CSR_DATA_W   = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VALUE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_ENABLE   = 2'd3;

   localparam logic [READING_W-1:0] PERIOD_RESET = 16'd40000;
   localparam logic [READING_W-1:0] CHARGE_RESET = 16'd2000;
   localparam logic [READING_W-1:0] MAX_RESET    = 16'hFFFF;

   // Per-tick control broadcast from the sequencer to every channel lane.
   typedef struct packed {
      logic                 accept;
      logic                 sample_en;
      logic                 wrap;
      logic [READING_W-1:0] count;
      logic [READING_W-1:0] max_value;
   } lane_ctrl_type;

   // One response as it leaves the merge stage.
   typedef struct packed {
      logic                                   drive_pins;
      logic                                   leds_on;
      logic                                   frame_done;
      logic [NUM_READINGS-1:0][READING_W-1:0] reading;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/rc_discharge_timer_capture.sv
// ----------------------------------------------------------------------------
// RC discharge timer capture
// Multi-channel RC-discharge reflectance sensor reader with frame output.
// ----------------------------------------------------------------------------
// Each request is one timer tick carrying the sampled sensor pin levels, and
// each request produces exactly one response. The block takes one request per
// clock: the period counter and every channel lane update in the single cycle
// in which a request is accepted, so the sustained rate is one tick per cycle
// whenever the response side keeps up. Responses leave through a two-entry
// output buffer, so a request can be accepted while the previous response is
// still waiting; req_stall rises only when both entries are full. On the wrap
// tick (counter at or above period_ticks) the response carries frame_done and
// the eight readings, reading_0 being the highest channel; a channel that never
// went low after the charge phase reports max_value. Configuration writes are
// expected only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_discharge_timer_capture
   import rcdt_pkg::*;
#(
   parameter int unsigned CHANNELS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [PIN_W-1:0]      req_pin_levels,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_drive_pins,
   output logic                       rsp_leds_on,
   output logic                       rsp_frame_done,
   output logic [READING_W-1:0]       rsp_reading_0,
   output logic [READING_W-1:0]       rsp_reading_1,
   output logic [READING_W-1:0]       rsp_reading_2,
   output logic [READING_W-1:0]       rsp_reading_3,
   output logic [READING_W-1:0]       rsp_reading_4,
   output logic [READING_W-1:0]       rsp_reading_5,
   output logic [READING_W-1:0]       rsp_reading_6,
   output logic [READING_W-1:0]       rsp_reading_7,

   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // Configuration registers.
   logic [READING_W-1:0] period_ff;
   logic [READING_W-1:0] charge_ff;
   logic [READING_W-1:0] max_value_ff;
   logic                 led_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= PERIOD_RESET;
         charge_ff     <= CHARGE_RESET;
         max_value_ff  <= MAX_RESET;
         led_enable_ff <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PERIOD_TICKS: period_ff     <= csr_data;
            CSR_CHARGE_TICKS: charge_ff     <= csr_data;
            CSR_MAX_VALUE:    max_value_ff  <= csr_data;
            CSR_LED_ENABLE:   led_enable_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Output buffer: the primary entry drives the ports, the skid entry catches
   // a request accepted while the primary is held by the downstream side.
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    out_valid_ff;
   logic    skid_valid_ff;
   logic    req_accept;
   logic    out_take;
   rsp_type new_rsp;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid & ~skid_valid_ff;
   assign out_take   = out_valid_ff & ~rsp_stall;

   // Tick sequencer: period counter and charge phase.
   logic [READING_W-1:0] tick_count_ff;
   logic [READING_W-1:0] tick_count_in;
   logic                 charging_ff;
   logic                 charging_in;
   logic                 wrap;
   logic                 release_pins;

   // Sampling sees the counter and charge state held before this tick; the
   // charge release is applied next and the wrap overrides it.
   assign wrap          = tick_count_ff >= period_ff;
   assign release_pins  = tick_count_ff == charge_ff;
   assign tick_count_in = wrap ? '0 : tick_count_ff + 1'b1;
   assign charging_in   = wrap | (charging_ff & ~release_pins);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         charging_ff   <= 1'b1;
      end else if (req_accept) begin
         tick_count_ff <= tick_count_in;
         charging_ff   <= charging_in;
      end
   end

   // Channel lanes, all sampling the same tick side by side.
   lane_ctrl_type                        lane_ctrl;
   logic [CHANNELS-1:0][READING_W-1:0]   lane_reading;

   assign lane_ctrl.accept    = req_accept;
   assign lane_ctrl.sample_en = ~charging_ff;
   assign lane_ctrl.wrap      = wrap;
   assign lane_ctrl.count     = tick_count_ff;
   assign lane_ctrl.max_value = max_value_ff;

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
      logic pin_level;

      // Channels past the physical pins always read low.
      if (ch < PIN_W) begin : g_pin
         assign pin_level = req_pin_levels[ch];
      end else begin : g_nopin
         assign pin_level = 1'b0;
      end

      rcdt_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .pin_level (pin_level),
         .reading   (lane_reading[ch])
      );
   end

   rcdt_merge #(
      .CHANNELS (CHANNELS)
   ) u_merge (
      .frame_done   (wrap),
      .drive_pins   (charging_in),
      .leds_on      (led_enable_ff),
      .lane_reading (lane_reading),
      .rsp          (new_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (out_take || !out_valid_ff) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else if (req_accept) begin
               out_ff       <= new_rsp;
               out_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b0;
            end
         end else if (req_accept) begin
            skid_ff       <= new_rsp;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_drive_pins = out_ff.drive_pins;
   assign rsp_leds_on    = out_ff.leds_on;
   assign rsp_frame_done = out_ff.frame_done;
   assign rsp_reading_0  = out_ff.reading[0];
   assign rsp_reading_1  = out_ff.reading[1];
   assign rsp_reading_2  = out_ff.reading[2];
   assign rsp_reading_3  = out_ff.reading[3];
   assign rsp_reading_4  = out_ff.reading[4];
   assign rsp_reading_5  = out_ff.reading[5];
   assign rsp_reading_6  = out_ff.reading[6];
   assign rsp_reading_7  = out_ff.reading[7];

endmodule

`default_nettype wire

>>> src/rcdt_lane.sv
// ----------------------------------------------------------------------------
// RC discharge timer channel lane
// Holds the armed flag and capture time of one sensor channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdt_lane
   import rcdt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lane_ctrl_type        ctrl,
   input  wire logic                 pin_level,
   output logic [READING_W-1:0]      reading
);

   logic                 armed_ff;
   logic                 armed_in;
   logic [READING_W-1:0] capture_ff;
   logic [READING_W-1:0] capture_in;
   logic                 fell;
   logic                 armed_upd;

   // A low sample only counts once the pins are released and the lane is armed.
   assign fell       = ctrl.sample_en & armed_ff & ~pin_level;
   assign armed_upd  = armed_ff & ~fell;
   assign capture_in = fell ? ctrl.count : capture_ff;
   assign armed_in   = ctrl.wrap | armed_upd;
   assign reading    = armed_upd ? ctrl.max_value : capture_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b1;
      end else if (ctrl.accept) begin
         armed_ff <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         capture_ff <= capture_in;
      end
   end

endmodule

`default_nettype wire

>>> src/rcdt_merge.sv
// ----------------------------------------------------------------------------
// RC discharge timer merge stage
// Gathers the lane readings into one response in reversed channel order.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdt_merge
   import rcdt_pkg::*;
#(
   parameter int unsigned CHANNELS = 8
) (
   input  wire logic                                 frame_done,
   input  wire logic                                 drive_pins,
   input  wire logic                                 leds_on,
   input  wire logic [CHANNELS-1:0][READING_W-1:0]   lane_reading,
   output rsp_type                                   rsp
);

   assign rsp.drive_pins = drive_pins;
   assign rsp.leds_on    = leds_on;
   assign rsp.frame_done = frame_done;

   // Field k carries channel CHANNELS-1-k; fields beyond the channel count are zero.
   for (genvar k = 0; k < NUM_READINGS; k++) begin : g_field
      if (k < CHANNELS) begin : g_used
         assign rsp.reading[k] = frame_done ? lane_reading[CHANNELS-1-k] : '0;
      end else begin : g_unused
         assign rsp.reading[k] = '0;
      end
   end

endmodule

`default_nettype wire
